@@ rtl/tma_pkg.sv @@
// Shared widths, limits and controller/datapath interface types for the trimmed average unit.
package tma_pkg;

  // Field widths
  localparam int SAMPLE_W   = 13;
  localparam int FRAC_W     = 8;
  localparam int TSUM_W     = 17;
  localparam int TMEAN_W    = 21;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // Output saturation limits
  localparam int TSUM_MAX  = 65535;
  localparam int TSUM_MIN  = -65536;
  localparam int TMEAN_MAX = 1048575;
  localparam int TMEAN_MIN = -1048576;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap;   // write the accepted sample into the window
    logic scan;  // read one window entry
    logic trim;  // form sum minus max minus min
    logic prep;  // load the divider input
    logic step;  // multiply by the scaled reciprocal of 2*(WINDOW-2)
    logic load;  // load the output register
  } tma_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;  // last window entry is being read
    logic out_free;   // output register can take a new request
  } tma_stat_t;

endpackage

@@ rtl/tma_ctrl.sv @@
// Controller state machine of the trimmed average unit.
module tma_ctrl import tma_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tma_stat_t stat,
  output tma_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_TRIM,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r;

  assign in_tready = in_rdy_r;

  // Command decode
  always_comb begin
    cmd      = '0;
    cmd.cap  = (state_r == S_IDLE) && in_tvalid && in_rdy_r;
    cmd.scan = (state_r == S_SCAN);
    cmd.trim = (state_r == S_TRIM);
    cmd.prep = (state_r == S_PREP);
    cmd.step = (state_r == S_DIV);
    cmd.load = (state_r == S_OUT) && stat.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd.cap) state_nxt = S_SCAN;
      S_SCAN:  if (stat.scan_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_TRIM;
      S_TRIM:  state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DIV;
      S_DIV:   state_nxt = S_OUT;
      S_OUT:   if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_rdy_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      in_rdy_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

@@ rtl/tma_dp.sv @@
// Datapath of the trimmed average unit: window memory, scan accumulators, divider, output register.
module tma_dp import tma_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tma_cmd_t              cmd,
  output tma_stat_t             stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW      = $clog2(WINDOW);
  localparam int SUM_W   = SAMPLE_W + AW;
  localparam int TRIM_W  = SUM_W + 1;
  // |trimmed| <= (WINDOW-2) * 4096 < 2^(SUM_W-1)
  localparam int MAG_W   = SUM_W - 1;
  localparam int NUM_W   = MAG_W + FRAC_W + 2;
  localparam int DIVISOR = WINDOW - 2;
  localparam int D2      = 2 * DIVISOR;
  // Reciprocal of D2, exact floor division for any numerator below 2^NUM_W
  localparam int REC_SH  = NUM_W + $clog2(D2);
  localparam int REC_W   = NUM_W + 2;
  localparam logic [REC_W-1:0] REC_M =
      REC_W'(((64'd1 << REC_SH) + 64'(D2 - 1)) / 64'(D2));
  localparam int PROD_W  = NUM_W + REC_W;
  localparam int QUO_W   = PROD_W - REC_SH;
  localparam int PAD_W   = OUT_DATA_W - TSUM_W - TMEAN_W;

  // Window store and its valid bits
  logic signed [SAMPLE_W-1:0] win_mem [WINDOW];
  logic [WINDOW-1:0]          vld_r;
  logic [AW-1:0]              wp_r;
  logic [AW-1:0]              rd_addr_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       rd_vld_r;
  logic                       acc_en_r;
  logic                       first_r;

  // Accumulators
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] hi_r;
  logic signed [SAMPLE_W-1:0] lo_r;
  logic signed [SAMPLE_W-1:0] cur;

  // Trim and divider
  logic signed [TRIM_W-1:0]   trim_r;
  logic [TRIM_W-1:0]          mag;
  logic                       neg_r;
  logic [NUM_W-1:0]           num_r;
  logic [PROD_W-1:0]          prod;
  logic [QUO_W-1:0]           quo_r;

  // Output stage
  logic signed [31:0]         t32;
  logic [31:0]                q32;
  logic signed [31:0]         sum_sat;
  logic signed [31:0]         mean_sat;
  logic                       out_vld_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  assign stat.scan_last = (rd_addr_r == AW'(WINDOW - 1));
  assign stat.out_free  = !out_vld_r || out_tready;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      win_mem[wp_r] <= signed'(in_tdata[SAMPLE_W-1:0]);
    end
    rd_data_r <= win_mem[rd_addr_r];
  end

  // Window control: write position, valid bits, scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      wp_r      <= '0;
      rd_addr_r <= '0;
      rd_vld_r  <= 1'b0;
      acc_en_r  <= 1'b0;
      first_r   <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr_r];
      acc_en_r <= cmd.scan;
      first_r  <= cmd.scan && (rd_addr_r == '0);
      if (cmd.cap) begin
        vld_r[wp_r] <= 1'b1;
        wp_r        <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);
        rd_addr_r   <= '0;
      end else if (cmd.scan && !stat.scan_last) begin
        rd_addr_r <= rd_addr_r + AW'(1);
      end
    end
  end

  // Never-written entries read as zero
  assign cur = rd_vld_r ? rd_data_r : '0;

  // Sum, max and min over the scan
  always_ff @(posedge clk) begin
    if (acc_en_r) begin
      if (first_r) begin
        sum_r <= SUM_W'(cur);
        hi_r  <= cur;
        lo_r  <= cur;
      end else begin
        sum_r <= sum_r + SUM_W'(cur);
        if (cur > hi_r) hi_r <= cur;
        if (cur < lo_r) lo_r <= cur;
      end
    end
  end

  // Trimmed sum, then divider load; rounding offset added before dividing by 2*(WINDOW-2)
  assign mag = trim_r[TRIM_W-1] ? TRIM_W'(-trim_r) : TRIM_W'(trim_r);

  // Division by the constant as a multiply by its scaled reciprocal
  assign prod = PROD_W'(num_r) * PROD_W'(REC_M);

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      trim_r <= TRIM_W'(sum_r) - TRIM_W'(hi_r) - TRIM_W'(lo_r);
    end
    if (cmd.prep) begin
      neg_r <= trim_r[TRIM_W-1];
      num_r <= NUM_W'({mag[MAG_W-1:0], {(FRAC_W + 1){1'b0}}}) + NUM_W'(DIVISOR);
    end
    if (cmd.step) begin
      quo_r <= prod[PROD_W-1:REC_SH];
    end
  end

  // Saturation of both results
  assign t32 = 32'(trim_r);
  assign q32 = 32'(quo_r);

  always_comb begin
    if (t32 > TSUM_MAX) begin
      sum_sat = TSUM_MAX;
    end else if (t32 < TSUM_MIN) begin
      sum_sat = TSUM_MIN;
    end else begin
      sum_sat = t32;
    end
    if (neg_r) begin
      mean_sat = (q32 > 32'(-TMEAN_MIN)) ? TMEAN_MIN : -signed'(q32);
    end else begin
      mean_sat = (q32 > 32'(TMEAN_MAX)) ? TMEAN_MAX : signed'(q32);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {{PAD_W{1'b0}}, mean_sat[TMEAN_W-1:0], sum_sat[TSUM_W-1:0]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/trimmed_moving_average_unit.sv @@
// Top level of the trimmed moving average unit: controller plus datapath.
//
//  channel | direction | tdata bits, lowest first
//  in_     | slave     | [12:0] sample, [15:13] zero
//  out_    | master    | [16:0] trimmed_sum, [37:17] trimmed_mean, [39:38] zero
//
//  Each sample is processed with one read of the window memory per entry, then one multiply
//  by the reciprocal of 2*(WINDOW-2).
//  in_tready is high only while idle; a finished result waits in the output register, and the
//  next sample is taken meanwhile, but a new result waits until that register is free.
//  Reset (rst_n low, synchronous) clears the per-entry valid bits, so the window reads as zeros.
module trimmed_moving_average_unit import tma_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [12:0] sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [16:0] trimmed_sum, [37:17] trimmed_mean
);

  tma_cmd_t  cmd;
  tma_stat_t stat;

  tma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tma_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // A taken request keeps the input closed while the window is scanned
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted request");

  // A zero trimmed sum gives a zero mean
  a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[16:0] == 17'd0)) |-> (out_tdata[37:17] == 21'd0))
    else $error("nonzero mean for zero trimmed sum");

  // The mean carries the sign of a nonzero trimmed sum
  a_mean_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[16:0] != 17'd0)) |-> (out_tdata[37] == out_tdata[16]))
    else $error("mean sign differs from trimmed sum sign");

  // Controller only loads a result into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending request");
`endif

endmodule

@@ sim/tb_trimmed_moving_average_unit.sv @@
// Self-checking testbench for the trimmed moving average unit: sample stream in, sum/mean out.
module tb_trimmed_moving_average_unit import tma_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = 16;
  localparam int N_ITEMS      = 550;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AT      = 250;
  localparam int TAIL_CYCLES  = 150;
  localparam int MAX_REPORTS  = 10;

  // Receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  // Shapes of random sample runs
  typedef enum int {SEG_NOISE, SEG_FLAT, SEG_RAIL, SEG_QUIET, SEG_DRIFT} seg_kind_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    bit                         drain;   // wait for all results before offering
  } sample_req_t;

  typedef struct {
    logic signed [TSUM_W-1:0]  tsum;
    logic signed [TMEAN_W-1:0] tmean;
  } avg_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  sample_req_t pending[$];
  avg_result_t expected_avgs[$];

  // Predictor state: the sample history and its write pointer
  logic signed [SAMPLE_W-1:0] hist_win[WIN];
  int                         hist_pos;

  int samples_sent    = 0;
  int results_checked = 0;
  int mismatch_cnt    = 0;
  int peak_sum        = 0;
  int trough_sum      = 0;

  trimmed_moving_average_unit #(.WINDOW(WIN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Push one sample into the history, then drop one max and one min and average the rest
  function automatic avg_result_t push_and_trim(input logic signed [SAMPLE_W-1:0] smp);
    avg_result_t r;
    int acc, top, bot, trimmed, mag, quo, mean;
    hist_win[hist_pos] = smp;
    hist_pos = (hist_pos + 1) % WIN;
    acc = hist_win[0];
    top = hist_win[0];
    bot = hist_win[0];
    for (int i = 1; i < WIN; i++) begin
      if (hist_win[i] > top) top = hist_win[i];
      if (hist_win[i] < bot) bot = hist_win[i];
      acc += hist_win[i];
    end
    trimmed = acc - top - bot;
    // round half away from zero on the magnitude
    mag  = (trimmed < 0) ? -trimmed : trimmed;
    quo  = (mag * (2 << FRAC_W) + (WIN - 2)) / (2 * (WIN - 2));
    mean = (trimmed < 0) ? -quo : quo;
    if (mean > TMEAN_MAX) mean = TMEAN_MAX;
    if (mean < TMEAN_MIN) mean = TMEAN_MIN;
    if (trimmed > TSUM_MAX) trimmed = TSUM_MAX;
    if (trimmed < TSUM_MIN) trimmed = TSUM_MIN;
    r.tsum  = trimmed[TSUM_W-1:0];
    r.tmean = mean[TMEAN_W-1:0];
    return r;
  endfunction

  task automatic queue_sample(input int v, input bit drain);
    sample_req_t r;
    r.value = v[SAMPLE_W-1:0];
    r.drain = drain;
    pending.push_back(r);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;
  bit offer;
  sample_req_t head;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        head = pending.pop_front();
        expected_avgs.push_back(push_and_trim(head.value));
        samples_sent++;
        offer = 1'b0;
      end
      if (!offer && pending.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending[0].drain && expected_avgs.size() > 0)) begin
          offer    = 1'b1;
          in_tdata <= {{(IN_DATA_W-SAMPLE_W){1'b0}}, pending[0].value};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
        end
      end
      in_tvalid <= offer;
    end
  end

  // Receiver: checks each result and stalls on its own pattern, with one long hold-off
  rx_mode_t rx_mode = RX_OPEN;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  rdy;
  int  rx_cycle  = 0;
  avg_result_t want;
  logic signed [TSUM_W-1:0]  got_sum;
  logic signed [TMEAN_W-1:0] got_mean;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_sum  = out_tdata[TSUM_W-1:0];
        got_mean = out_tdata[TSUM_W +: TMEAN_W];
        if (expected_avgs.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("[%0t] unexpected result: sum %0d mean %0d", $time, got_sum, got_mean);
        end else begin
          want = expected_avgs.pop_front();
          results_checked++;
          if (want.tsum > peak_sum) peak_sum = want.tsum;
          if (want.tsum < trough_sum) trough_sum = want.tsum;
          if (got_sum !== want.tsum || got_mean !== want.tmean) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("[%0t] result %0d: sum exp %0d got %0d, mean exp %0d got %0d",
                       $time, results_checked, want.tsum, got_sum, want.tmean, got_mean);
          end
        end
      end

      // long hold-off so the unit backs up into its input
      if (!hold_done && results_checked >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:     rdy = 1'b1;
          RX_COIN:     rdy = 1'($urandom_range(0, 1));
          RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
          default:     rdy = (rx_cycle % 5 != 0);
        endcase
      end
      out_tready <= rdy;
    end
  end

  // Watchdog on handshake activity
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles, %0d samples sent, %0d results checked",
                 $time, idle_cycles, samples_sent, results_checked);
        $display("FAIL trimmed_moving_average_unit");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int directed_vals[15] = '{0, 4095, -4096, 4095, 4095, -4096, -4096,
                              1, -1, 3, -3, 7, -7, 2730, -2731};
    int seg, len, v, base;
    seg_kind_t kind;

    for (int i = 0; i < WIN; i++) hist_win[i] = '0;
    hist_pos = 0;

    // directed: zero window, rails, repeated extremes, small values of both signs
    foreach (directed_vals[i]) queue_sample(directed_vals[i], 1'b0);

    // random runs; the first two fill the whole window with each rail
    seg = 0;
    while (pending.size() < N_ITEMS) begin
      kind = (seg < 2) ? SEG_RAIL : seg_kind_t'($urandom_range(0, 4));
      base = int'($urandom_range(0, 8191)) - 4096;
      case (kind)
        SEG_NOISE: len = $urandom_range(5, 40);
        SEG_FLAT:  len = $urandom_range(1, 20);
        SEG_RAIL:  len = $urandom_range(WIN, WIN + 4);
        SEG_QUIET: len = $urandom_range(5, 30);
        default:   len = $urandom_range(10, 40);
      endcase
      if (kind == SEG_RAIL)
        base = (seg == 0) ? 4095 : (seg == 1) ? -4096 : ($urandom_range(0, 1) ? 4095 : -4096);
      for (int k = 0; k < len && pending.size() < N_ITEMS; k++) begin
        case (kind)
          SEG_NOISE: v = int'($urandom_range(0, 8191)) - 4096;
          SEG_QUIET: v = int'($urandom_range(0, 40)) - 20;
          SEG_DRIFT: begin
            base += int'($urandom_range(0, 40)) - 20;
            if (base > 4095) base = 4095;
            if (base < -4096) base = -4096;
            // occasional spike that the trimming should take out
            v = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 4095 : -4096) : base;
          end
          default:   v = base;
        endcase
        // sender drains the pipe before a couple of runs
        queue_sample(v, (k == 0) && (seg == 0 || seg == 15));
      end
      seg++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || expected_avgs.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d runs, checked %0d results; trimmed sum ranged %0d..%0d",
             samples_sent, seg, results_checked, trough_sum, peak_sum);
    $display("Receiver hold-off of %0d cycles and a full drain of the pipe were exercised",
             HOLD_CYCLES);
    if (mismatch_cnt == 0 && expected_avgs.size() == 0) begin
      $display("PASS trimmed_moving_average_unit");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_cnt, expected_avgs.size());
      $display("FAIL trimmed_moving_average_unit");
    end
    $finish;
  end

endmodule
